[rtl/iff_pkg.sv]
// ----------------------------------------------------------------------------
// IFF field finder package
// Shared types and constants for the IFF form field finder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package iff_pkg;

  localparam logic [31:0] FORM_TAG = 32'h464F_524D;  // 'FORM'

  localparam int unsigned POS_W  = 33;  // byte offsets within the outer chunk
  localparam int unsigned SPAN_W = 34;  // child start plus header and data span

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WANTED_FORM_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_FIELD     = 1'b1;

  // First child header sits after type, size and subtype of the outer FORM.
  localparam logic [POS_W-1:0] FIRST_CHILD = 33'd12;

  typedef enum logic [1:0] {
    OUTCOME_FOUND    = 2'd0,
    OUTCOME_MISMATCH = 2'd1,
    OUTCOME_NOTFOUND = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_OUTER = 2'd1,
    PH_CHILD = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_form;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic [POS_W-1:0] chunk_offset;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/iff_form_field_finder.sv]
// ----------------------------------------------------------------------------
// IFF form field finder
// Byte-stream parser that locates a child chunk inside an outer IFF chunk.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle with no gaps needed, as long as no
// finished result is held back: every byte is held in an input register,
// decoded against the header counters and a four-byte shift register, and
// any result lands in an output register. The input stays ready while a
// result waits, as long as the byte in the input register does not itself
// end a search. Each search that runs to its end gives one result: found
// with the child header offset, form type mismatch, or not found. A byte
// with start_of_form set always restarts the search; bytes outside a search
// are dropped. The user must write configuration through the plain write
// port only while no byte is in flight; the block itself does not enforce it.
`default_nettype none

module iff_form_field_finder (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [iff_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [iff_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire iff_pkg::in_item_t                  in_data_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      iff_pkg::out_item_t                 out_data_o
);
  import iff_pkg::*;

  // configuration
  logic [31:0] wanted_form_type_q, wanted_field_q;

  // input and output registers
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // parser state
  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [31:0]        hs_q, hs_d;
  logic [POS_W-1:0]   end_q, end_d;
  logic [POS_W-1:0]   cs_q, cs_d;
  logic [POS_W-1:0]   cn_q, cn_d;
  logic [31:0]        ck_q, ck_d;

  // state as seen by the current byte (cleared by a start flag)
  phase_e             cur_ph;
  logic [POS_W-1:0]   cur_pos, cur_end, cur_cs, cur_cn;
  logic [31:0]        cur_hs, cur_ck;

  logic [31:0]        hs_new;
  logic [POS_W-1:0]   span;
  logic [POS_W-1:0]   rel;
  logic               before_child;
  logic [SPAN_W-1:0]  nxt;

  // decode results
  logic               fin;
  outcome_e           fin_code;
  logic               set_ck, set_end, set_cn;
  logic               enter;
  logic [SPAN_W-1:0]  enter_c;
  logic [POS_W-1:0]   end_eff;
  logic               enter_nf;
  logic               emit;
  outcome_e           emit_code;

  logic               advance;

  // hold only a byte that ends a search while a result still waits
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    if (in_q.start_of_form) begin
      cur_ph  = PH_OUTER;
      cur_pos = '0;
      cur_hs  = '0;
      cur_end = '0;
      cur_cs  = '0;
      cur_cn  = '0;
      cur_ck  = '0;
    end else begin
      cur_ph  = phase_q;
      cur_pos = pos_q;
      cur_hs  = hs_q;
      cur_end = end_q;
      cur_cs  = cs_q;
      cur_cn  = cn_q;
      cur_ck  = ck_q;
    end
  end

  assign hs_new       = {cur_hs[23:0], in_q.data_byte};
  // header size plus pad byte plus eight header bytes
  assign span         = POS_W'(33'd8 + {1'b0, hs_new} + {32'd0, hs_new[0]});
  assign rel          = cur_pos - cur_cs;
  assign before_child = cur_pos < cur_cs;
  assign nxt          = {1'b0, cur_cs} + {1'b0, span};

  // decode the current byte
  always_comb begin
    fin      = 1'b0;
    fin_code = OUTCOME_NOTFOUND;
    set_ck   = 1'b0;
    set_end  = 1'b0;
    set_cn   = 1'b0;
    enter    = 1'b0;
    enter_c  = '0;
    case (cur_ph)
      PH_OUTER: begin
        if (cur_pos == 33'd3) begin
          set_ck = 1'b1;
          if (hs_new != FORM_TAG && wanted_form_type_q != '0) begin
            fin      = 1'b1;
            fin_code = OUTCOME_MISMATCH;
          end
        end else if (cur_pos == 33'd7) begin
          set_end = 1'b1;
          if (cur_ck != FORM_TAG) begin
            enter   = 1'b1;
            enter_c = {1'b0, FIRST_CHILD};
          end
        end else if (cur_pos == 33'd11) begin
          if (hs_new != wanted_form_type_q) begin
            fin      = 1'b1;
            fin_code = OUTCOME_MISMATCH;
          end else begin
            enter   = 1'b1;
            enter_c = {1'b0, FIRST_CHILD};
          end
        end
      end
      PH_CHILD: begin
        if (!before_child) begin
          if (rel == 33'd3) begin
            set_ck = 1'b1;
            if (hs_new == wanted_field_q) begin
              fin      = 1'b1;
              fin_code = OUTCOME_FOUND;
            end
          end else if (rel == 33'd7) begin
            // nested FORM with room for a subtype: check it at byte eleven
            if (cur_ck == FORM_TAG && hs_new >= 32'd3) begin
              set_cn = 1'b1;
            end else begin
              enter   = 1'b1;
              enter_c = nxt;
            end
          end else if (rel == 33'd11) begin
            if (hs_new == wanted_field_q) begin
              fin      = 1'b1;
              fin_code = OUTCOME_FOUND;
            end else begin
              enter   = 1'b1;
              enter_c = {1'b0, cur_cn};
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign end_eff   = set_end ? span : cur_end;
  assign enter_nf  = enter && (enter_c >= {1'b0, end_eff});
  assign emit      = (cur_ph != PH_IDLE) && (fin || enter_nf);
  assign emit_code = fin ? fin_code : OUTCOME_NOTFOUND;

  // next state
  always_comb begin
    phase_d = cur_ph;
    pos_d   = cur_pos;
    hs_d    = cur_hs;
    end_d   = cur_end;
    cs_d    = cur_cs;
    cn_d    = cur_cn;
    ck_d    = cur_ck;
    if (cur_ph != PH_IDLE) begin
      pos_d = cur_pos + 33'd1;
      hs_d  = hs_new;
      if (set_ck) begin
        ck_d = hs_new;
      end
      if (set_end) begin
        end_d = span;
      end
      if (set_cn) begin
        cn_d = (nxt >= {1'b0, cur_end}) ? cur_end : nxt[POS_W-1:0];
      end
      if (fin || enter_nf) begin
        phase_d = PH_IDLE;
      end else if (enter) begin
        phase_d = PH_CHILD;
        cs_d    = enter_c[POS_W-1:0];
      end
    end
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_form_type_q <= '0;
      wanted_field_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WANTED_FORM_TYPE: wanted_form_type_q <= cfg_wdata_i;
        REG_WANTED_FIELD:     wanted_field_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      hs_q        <= '0;
      end_q       <= '0;
      cs_q        <= '0;
      cn_q        <= '0;
      ck_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        hs_q    <= hs_d;
        end_q   <= end_d;
        cs_q    <= cs_d;
        cn_q    <= cn_d;
        ck_q    <= ck_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q.outcome      <= emit_code;
      out_q.chunk_offset <= (fin && fin_code == OUTCOME_FOUND) ? cur_cs : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/iff_chk.sv]
// ----------------------------------------------------------------------------
// IFF field finder checker
// Port-level assertions for the IFF form field finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire iff_pkg::out_item_t  out_data_o
);
  import iff_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.outcome == OUTCOME_FOUND ||
                     out_data_o.outcome == OUTCOME_MISMATCH ||
                     out_data_o.outcome == OUTCOME_NOTFOUND))
    else $error("undefined outcome code");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome != OUTCOME_FOUND |-> out_data_o.chunk_offset == '0)
    else $error("offset set on a result that is not a find");

  a_found_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUTCOME_FOUND |->
      out_data_o.chunk_offset >= FIRST_CHILD)
    else $error("found child lies inside the outer header");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

endmodule

bind iff_form_field_finder iff_chk u_iff_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// IFF form field finder testbench
// Streams chunk images byte by byte into the finder, tracks each search in a
// local model of the parser and checks every result against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import iff_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 210;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [31:0] TAG_AIFF = 32'h4149_4646;
  localparam logic [31:0] TAG_COMM = 32'h434F_4D4D;
  localparam logic [31:0] TAG_ILBM = 32'h494C_424D;
  localparam logic [31:0] TAG_BODY = 32'h424F_4459;
  localparam logic [31:0] TAG_CHRS = 32'h4348_5253;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_WANTED_FORM_TYPE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  out_item_t             out_data_o;

  iff_form_field_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  in_item_t  byte_fifo[$];
  out_item_t search_results_due[$];
  int        bytes_queued = 0;
  int        bytes_taken  = 0;
  int        fail_count   = 0;
  int        tx_idle_pct  = 0;
  int        rx_idle_pct  = 0;
  int        hold_left    = 0;
  bit        hold_req     = 1'b0;
  bit        hold_done    = 1'b0;
  bit        in_fire      = 1'b0;

  // Values the stimulus aims at; the search model keeps its own copy below.
  logic [31:0] gen_form  = '0;
  logic [31:0] gen_field = '0;

  // Search model state
  logic [31:0] want_form_q  = '0;
  logic [31:0] want_field_q = '0;
  logic [32:0] srch_pos     = '0;
  logic [31:0] srch_shift   = '0;
  logic [32:0] srch_end     = '0;
  logic [32:0] srch_child   = '0;
  logic [32:0] srch_next    = '0;
  logic [31:0] srch_kind    = '0;
  phase_e      srch_phase   = PH_IDLE;

  task automatic close_search(input outcome_e code, input logic [32:0] offset);
    out_item_t res;
    res.outcome      = code;
    res.chunk_offset = offset;
    search_results_due.push_back(res);
    srch_phase = PH_IDLE;
  endtask

  task automatic open_child(input logic [33:0] hdr);
    if (hdr >= srch_end) begin
      close_search(OUTCOME_NOTFOUND, '0);
    end else begin
      srch_child = hdr[32:0];
      srch_phase = PH_CHILD;
    end
  endtask

  task automatic track_search(input in_item_t it);
    logic [32:0] p;
    logic [32:0] r;
    logic [33:0] nxt;
    if (it.start_of_form) begin
      srch_pos   = '0;
      srch_shift = '0;
      srch_end   = '0;
      srch_child = '0;
      srch_next  = '0;
      srch_kind  = '0;
      srch_phase = PH_OUTER;
    end
    if (srch_phase == PH_IDLE) return;
    p          = srch_pos;
    srch_shift = {srch_shift[23:0], it.data_byte};
    srch_pos   = p + 33'd1;
    if (srch_phase == PH_OUTER) begin
      if (p == 33'd3) begin
        srch_kind = srch_shift;
        if (srch_kind != FORM_TAG && want_form_q != 0) close_search(OUTCOME_MISMATCH, '0);
      end else if (p == 33'd7) begin
        srch_end = 33'd8 + {1'b0, srch_shift} + {32'd0, srch_shift[0]};
        // non-FORM outer: no subtype, skip bytes 8 to 11
        if (srch_kind != FORM_TAG) open_child({1'b0, FIRST_CHILD});
      end else if (p == 33'd11) begin
        if (srch_shift != want_form_q) close_search(OUTCOME_MISMATCH, '0);
        else open_child({1'b0, FIRST_CHILD});
      end
    end else if (p >= srch_child) begin
      r = p - srch_child;
      if (r == 33'd3) begin
        srch_kind = srch_shift;
        if (srch_kind == want_field_q) close_search(OUTCOME_FOUND, srch_child);
      end else if (r == 33'd7) begin
        nxt = {1'b0, srch_child} + 34'd8 + {2'b00, srch_shift} + {33'd0, srch_shift[0]};
        // nested FORM long enough to carry a subtype: hold the next offset
        if (srch_kind == FORM_TAG && nxt >= {1'b0, srch_child} + 34'd12) begin
          srch_next = (nxt >= {1'b0, srch_end}) ? srch_end : nxt[32:0];
        end else begin
          open_child(nxt);
        end
      end else if (r == 33'd11) begin
        if (srch_shift == want_field_q) close_search(OUTCOME_FOUND, srch_child);
        else open_child({1'b0, srch_next});
      end
    end
  endtask

  // Monitor: config writes, result checks, byte transfers
  always @(posedge clk_i) begin : monitor
    out_item_t due;
    in_fire = 1'b0;
    if (rst_ni) begin
      if (cfg_we) begin
        if (cfg_idx == REG_WANTED_FORM_TYPE) want_form_q = cfg_wdata;
        else if (cfg_idx == REG_WANTED_FIELD) want_field_q = cfg_wdata;
      end
      if (out_valid_o && out_ready) begin
        if (search_results_due.size() == 0) begin
          $error("result with none outstanding: outcome %0d, chunk_offset %0d",
                 out_data_o.outcome, out_data_o.chunk_offset);
          fail_count++;
        end else begin
          due = search_results_due.pop_front();
          if (out_data_o.outcome !== due.outcome) begin
            $error("outcome: expected %0d, actual %0d", due.outcome, out_data_o.outcome);
            fail_count++;
          end
          if (out_data_o.chunk_offset !== due.chunk_offset) begin
            $error("chunk_offset: expected %0d, actual %0d",
                   due.chunk_offset, out_data_o.chunk_offset);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        in_fire = 1'b1;
        bytes_taken++;
        track_search(in_data);
      end
    end
  end

  // Driver: hold each byte until its transfer, then advance
  always @(negedge clk_i) begin
    if (!in_valid || in_fire) begin
      if (byte_fifo.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_data  <= byte_fifo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic push_item(input logic [7:0] b, input bit sof);
    in_item_t it;
    it.data_byte     = b;
    it.start_of_form = sof;
    byte_fifo.push_back(it);
    bytes_queued++;
  endtask

  task automatic put_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 3; i >= 0; i--) q.push_back(w[8*i +: 8]);
  endtask

  task automatic send_image(ref logic [7:0] img[$]);
    foreach (img[i]) push_item(img[i], i == 0 || $urandom_range(0, 59) == 0);
  endtask

  // Build and push one outer chunk image with random children, or a short run of random bytes
  task automatic add_random_image();
    logic [7:0]  img[$];
    logic [7:0]  kids[$];
    logic [31:0] kind;
    logic [31:0] csize;
    logic [31:0] nested;
    logic [31:0] outer_type;
    logic [31:0] sub;
    logic [31:0] osize;
    int          n_kids;
    int          cut;
    bit          big;
    if ($urandom_range(0, 9) == 0) begin
      n_kids = $urandom_range(1, 12);
      for (int i = 0; i < n_kids; i++) begin
        push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      return;
    end
    n_kids = $urandom_range(0, 4);
    for (int k = 0; k < n_kids; k++) begin
      case ($urandom_range(0, 5))
        0:       kind = gen_field;
        1:       kind = FORM_TAG;
        2:       kind = $urandom;
        3:       kind = TAG_BODY;
        4:       kind = TAG_CHRS;
        default: kind = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
      nested = $urandom_range(0, 1) ? gen_field : $urandom;
      big    = ($urandom_range(0, 24) == 0);
      csize  = big ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom) : $urandom_range(0, 9);
      put_word(kids, kind);
      put_word(kids, csize);
      if (big) begin
        // oversized child: give it a subtype and end the image there
        put_word(kids, (kind == FORM_TAG) ? nested : $urandom);
        break;
      end
      for (int j = 0; j < csize; j++) begin
        if (kind == FORM_TAG && j < 4) kids.push_back(nested[8*(3-j) +: 8]);
        else kids.push_back(8'($urandom_range(0, 255)));
      end
      if (csize[0]) kids.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) outer_type = $urandom_range(0, 1) ? TAG_LIST : $urandom;
    else outer_type = FORM_TAG;
    sub   = ($urandom_range(0, 7) == 0) ? $urandom : gen_form;
    osize = 4 + kids.size();
    case ($urandom_range(0, 15))
      0:       osize = $urandom_range(0, osize + 8);
      1:       osize = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      2:       osize = $urandom;
      default: ;
    endcase
    put_word(img, outer_type);
    put_word(img, osize);
    put_word(img, sub);
    foreach (kids[i]) img.push_back(kids[i]);
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, img.size());
      while (img.size() > cut) void'(img.pop_back());
    end
    send_image(img);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Wait for every byte and result, then let the pipeline settle
  task automatic drain();
    while (bytes_taken != bytes_queued || search_results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  logic [31:0] phase_form[6];
  logic [31:0] phase_field[6];

  initial begin
    int start_count;
    phase_form  = '{TAG_AIFF, 32'h0, 32'hFFFF_FFFF, $urandom, TAG_ILBM, 32'h0};
    phase_field = '{TAG_COMM, FORM_TAG, 32'hFFFF_FFFF, 32'h0, TAG_BODY, $urandom};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(9, 63);

    // Directed, at reset config: idle bytes, short outer FORM, restart, found
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h46, 1'b1);
    push_item(8'h4F, 1'b0);
    push_item(8'h52, 1'b0);
    push_item(8'h4D, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h04, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h46, 1'b1);
    for (int i = 0; i < 4; i++) push_item(FORM_TAG[8*(3-i) +: 8], i == 0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h0C, 1'b0);
    for (int i = 0; i < 8; i++) push_item(8'h00, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 2) set_idle(9, 63);
      else if (ph < 4) set_idle(63, 9);
      else set_idle(0, 0);
      gen_form  = phase_form[ph];
      gen_field = phase_field[ph];
      write_reg(REG_WANTED_FORM_TYPE, gen_form);
      write_reg(REG_WANTED_FIELD, gen_field);
      @(posedge clk_i);
      start_count = bytes_queued;
      while (bytes_queued - start_count < PHASE_BYTES) add_random_image();
      // stall the result side while bytes keep coming, so the block backs up
      if (ph == 4) hold_req = 1'b1;
    end
    drain();

    if (fail_count == 0 && search_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
